>>> hdl/sbd_pkg.sv
`timescale 1ns / 1ps
package sbd_pkg;

  localparam int unsigned CoordW = 16;
  localparam int unsigned TagW   = 8;
  localparam int unsigned SqW    = 33;
  localparam int unsigned KeyW   = 34;
  localparam int unsigned CfgIdxW = 2;

  // configuration register indexes
  typedef enum logic [CfgIdxW-1:0] {
    CFG_REF_X        = 2'd0,
    CFG_REF_Y        = 2'd1,
    CFG_REF_Z        = 2'd2,
    CFG_NEAREST_ONLY = 2'd3
  } cfg_idx_e;

  // one classified point as it travels from front to back
  typedef struct packed {
    logic [TagW-1:0]   tag;
    logic [CoordW-1:0] x;
    logic [CoordW-1:0] y;
    logic [CoordW-1:0] z;
    logic [KeyW-1:0]   key;
    logic              last;
  } point_t;

  typedef enum logic [2:0] {
    ST_LOAD,
    ST_SCAN,
    ST_SETTLE,
    ST_FETCH,
    ST_SEND
  } back_state_e;

endpackage

>>> hdl/sort_points_by_distance_core.sv
`timescale 1ns / 1ps
// channel   | handshake                 | payload
// input     | in_valid_i / in_stall_o   | point_tag_i, coord_x/y/z_i, list_end_i
// output    | out_valid_o / out_stall_i | out_tag_o, out_x/y/z_o, dist_sq_o,
//           |                           | run_end_o, overflowed_o
// config    | cfg_we_i                  | cfg_idx_i, cfg_wdata_i
//
// loading takes one request per cycle while the 4-entry queue has room
// each result takes one pass over the n points held in the point memory
// (one read port), which finds the next smallest unsent distance
// reset clears the queue, counts and sent marks; the point memory is not cleared
// a stalled result holds, while the front keeps filling the queue
module sort_points_by_distance_core #(
  parameter int unsigned MAX_POINTS = 64
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [sbd_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [sbd_pkg::CoordW-1:0]    cfg_wdata_i,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [sbd_pkg::TagW-1:0]      point_tag_i,
  input  logic signed [sbd_pkg::CoordW-1:0] coord_x_i,
  input  logic signed [sbd_pkg::CoordW-1:0] coord_y_i,
  input  logic signed [sbd_pkg::CoordW-1:0] coord_z_i,
  input  logic                          list_end_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [sbd_pkg::TagW-1:0]      out_tag_o,
  output logic signed [sbd_pkg::CoordW-1:0] out_x_o,
  output logic signed [sbd_pkg::CoordW-1:0] out_y_o,
  output logic signed [sbd_pkg::CoordW-1:0] out_z_o,
  output logic [sbd_pkg::KeyW-1:0]      dist_sq_o,
  output logic                          run_end_o,
  output logic                          overflowed_o
);
  import sbd_pkg::*;

  logic [CoordW-1:0] ref_x_q, ref_y_q, ref_z_q;
  logic              nearest_q;
  logic   push, full, pop, q_valid;
  point_t push_data, pop_data;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ref_x_q   <= '0;
      ref_y_q   <= '0;
      ref_z_q   <= '0;
      nearest_q <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_REF_X:        ref_x_q   <= cfg_wdata_i;
        CFG_REF_Y:        ref_y_q   <= cfg_wdata_i;
        CFG_REF_Z:        ref_z_q   <= cfg_wdata_i;
        CFG_NEAREST_ONLY: nearest_q <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  // front: squared distance per point
  sbd_front u_front (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o,
    .point_tag_i, .coord_x_i, .coord_y_i, .coord_z_i, .list_end_i,
    .ref_x_i(ref_x_q), .ref_y_i(ref_y_q), .ref_z_i(ref_z_q),
    .push_o(push), .push_data_o(push_data), .full_i(full)
  );

  // short queue decouples loading from the sort passes
  sbd_fifo u_fifo (
    .clk_i, .rst_ni, .push_i(push), .push_data_i(push_data), .full_o(full),
    .pop_i(pop), .valid_o(q_valid), .pop_data_o(pop_data)
  );

  // back: point store and selection passes
  sbd_back #(.MAX_POINTS(MAX_POINTS)) u_back (
    .clk_i, .rst_ni, .q_valid_i(q_valid), .q_data_i(pop_data), .q_pop_o(pop),
    .nearest_only_i(nearest_q), .out_valid_o, .out_stall_i,
    .out_tag_o, .out_x_o, .out_y_o, .out_z_o, .dist_sq_o,
    .run_end_o, .overflowed_o
  );

endmodule

>>> hdl/sbd_front.sv
`timescale 1ns / 1ps
module sbd_front (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [sbd_pkg::TagW-1:0]      point_tag_i,
  input  logic signed [sbd_pkg::CoordW-1:0] coord_x_i,
  input  logic signed [sbd_pkg::CoordW-1:0] coord_y_i,
  input  logic signed [sbd_pkg::CoordW-1:0] coord_z_i,
  input  logic                          list_end_i,
  input  logic signed [sbd_pkg::CoordW-1:0] ref_x_i,
  input  logic signed [sbd_pkg::CoordW-1:0] ref_y_i,
  input  logic signed [sbd_pkg::CoordW-1:0] ref_z_i,
  output logic                          push_o,
  output sbd_pkg::point_t               push_data_o,
  input  logic                          full_i
);
  import sbd_pkg::*;

  logic              v_q;
  logic [TagW-1:0]   tag_q;
  logic [CoordW-1:0] x_q, y_q, z_q;
  logic              last_q;
  logic [SqW-1:0]    sqx_q, sqy_q, sqz_q;
  logic signed [CoordW:0]     dx, dy, dz;
  logic signed [2*CoordW+1:0] px, py, pz;
  logic advance;

  // 17-bit signed differences, squared at accept time
  assign dx = {coord_x_i[CoordW-1], coord_x_i} - {ref_x_i[CoordW-1], ref_x_i};
  assign dy = {coord_y_i[CoordW-1], coord_y_i} - {ref_y_i[CoordW-1], ref_y_i};
  assign dz = {coord_z_i[CoordW-1], coord_z_i} - {ref_z_i[CoordW-1], ref_z_i};
  assign px = dx * dx;
  assign py = dy * dy;
  assign pz = dz * dz;

  assign push_o  = v_q && !full_i;
  assign advance = !v_q || push_o;
  assign in_stall_o = !advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= 1'b0;
    end else if (advance) begin
      v_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && in_valid_i) begin
      tag_q  <= point_tag_i;
      x_q    <= coord_x_i;
      y_q    <= coord_y_i;
      z_q    <= coord_z_i;
      last_q <= list_end_i;
      sqx_q  <= px[SqW-1:0];
      sqy_q  <= py[SqW-1:0];
      sqz_q  <= pz[SqW-1:0];
    end
  end

  always_comb begin
    push_data_o.tag  = tag_q;
    push_data_o.x    = x_q;
    push_data_o.y    = y_q;
    push_data_o.z    = z_q;
    push_data_o.key  = KeyW'(sqx_q) + KeyW'(sqy_q) + KeyW'(sqz_q);
    push_data_o.last = last_q;
  end

endmodule

>>> hdl/sbd_fifo.sv
`timescale 1ns / 1ps
module sbd_fifo (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  sbd_pkg::point_t push_data_i,
  output logic            full_o,
  input  logic            pop_i,
  output logic            valid_o,
  output sbd_pkg::point_t pop_data_o
);
  import sbd_pkg::*;

  localparam int unsigned Depth = 4;
  localparam int unsigned PtrW  = $clog2(Depth);

  point_t          slot_q [Depth];
  logic [PtrW-1:0] wr_q, rd_q;
  logic [PtrW:0]   cnt_q;

  assign full_o     = (cnt_q == (PtrW+1)'(Depth));
  assign valid_o    = (cnt_q != '0);
  assign pop_data_o = slot_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) wr_q <= wr_q + 1'b1;
      if (pop_i)  rd_q <= rd_q + 1'b1;
      if (push_i && !pop_i)      cnt_q <= cnt_q + 1'b1;
      else if (pop_i && !push_i) cnt_q <= cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) slot_q[wr_q] <= push_data_i;
  end

endmodule

>>> hdl/sbd_back.sv
`timescale 1ns / 1ps
module sbd_back #(
  parameter int unsigned MAX_POINTS = 64
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     q_valid_i,
  input  sbd_pkg::point_t          q_data_i,
  output logic                     q_pop_o,
  input  logic                     nearest_only_i,
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output logic [sbd_pkg::TagW-1:0] out_tag_o,
  output logic signed [sbd_pkg::CoordW-1:0] out_x_o,
  output logic signed [sbd_pkg::CoordW-1:0] out_y_o,
  output logic signed [sbd_pkg::CoordW-1:0] out_z_o,
  output logic [sbd_pkg::KeyW-1:0] dist_sq_o,
  output logic                     run_end_o,
  output logic                     overflowed_o
);
  import sbd_pkg::*;

  localparam int unsigned AW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
  localparam int unsigned CW = $clog2(MAX_POINTS + 1);

  point_t mem [MAX_POINTS];

  back_state_e state_q, state_d;
  logic [CW-1:0]   cnt_q, rank_q, n_out;
  logic            ovf_q;
  logic [AW-1:0]   scan_q, rd_addr, rd_idx_q, best_idx_q;
  logic            rd_en, rd_vld_q, best_vld_q;
  logic [KeyW-1:0] best_key_q;
  point_t          rd_data_q;
  logic [MAX_POINTS-1:0] done_q;
  logic            room, scan_end, out_fire, run_last;

  assign room     = (cnt_q < CW'(MAX_POINTS));
  assign n_out    = nearest_only_i ? CW'(1) : cnt_q;
  assign scan_end = (CW'(scan_q) + CW'(1) == cnt_q);
  assign run_last = (rank_q + CW'(1) == n_out);
  assign out_fire = (state_q == ST_SEND) && !out_stall_i;

  always_comb begin
    state_d = state_q;
    q_pop_o = 1'b0;
    rd_en   = 1'b0;
    rd_addr = scan_q;
    unique case (state_q)
      ST_LOAD: begin
        q_pop_o = q_valid_i;
        if (q_valid_i && q_data_i.last) state_d = ST_SCAN;
      end
      ST_SCAN: begin
        rd_en = 1'b1;
        if (scan_end) state_d = ST_SETTLE;
      end
      ST_SETTLE: state_d = ST_FETCH;
      ST_FETCH: begin
        rd_en   = 1'b1;
        rd_addr = best_idx_q;
        state_d = ST_SEND;
      end
      ST_SEND: begin
        if (!out_stall_i) state_d = run_last ? ST_LOAD : ST_SCAN;
      end
      default: state_d = ST_LOAD;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_LOAD;
      cnt_q      <= '0;
      ovf_q      <= 1'b0;
      scan_q     <= '0;
      rank_q     <= '0;
      rd_vld_q   <= 1'b0;
      best_vld_q <= 1'b0;
      done_q     <= '0;
    end else begin
      state_q  <= state_d;
      rd_vld_q <= (state_q == ST_SCAN);
      if (q_pop_o) begin
        if (room) cnt_q <= cnt_q + 1'b1;
        else      ovf_q <= 1'b1;
      end
      if (state_q == ST_SCAN) scan_q <= scan_q + 1'b1;
      // running minimum, strict compare keeps the earliest of equal keys
      if (rd_vld_q && !done_q[rd_idx_q] &&
          (!best_vld_q || rd_data_q.key < best_key_q)) begin
        best_vld_q <= 1'b1;
      end
      if (out_fire) begin
        scan_q     <= '0;
        best_vld_q <= 1'b0;
        if (run_last) begin
          cnt_q  <= '0;
          ovf_q  <= 1'b0;
          rank_q <= '0;
          done_q <= '0;
        end else begin
          rank_q <= rank_q + 1'b1;
          done_q[best_idx_q] <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (q_pop_o && room) mem[cnt_q[AW-1:0]] <= q_data_i;
    if (rd_en) begin
      rd_data_q <= mem[rd_addr];
      rd_idx_q  <= rd_addr;
    end
    if (rd_vld_q && !done_q[rd_idx_q] &&
        (!best_vld_q || rd_data_q.key < best_key_q)) begin
      best_key_q <= rd_data_q.key;
      best_idx_q <= rd_idx_q;
    end
  end

  assign out_valid_o  = (state_q == ST_SEND);
  assign out_tag_o    = rd_data_q.tag;
  assign out_x_o      = rd_data_q.x;
  assign out_y_o      = rd_data_q.y;
  assign out_z_o      = rd_data_q.z;
  assign dist_sq_o    = rd_data_q.key;
  assign run_end_o    = run_last;
  assign overflowed_o = ovf_q;

endmodule

>>> sim/sort_points_checker.sv
`timescale 1ns / 1ps
module sort_points_checker #(
  parameter int unsigned MAX_POINTS = 64
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [sbd_pkg::CfgIdxW-1:0]       cfg_idx_i,
  input  logic [sbd_pkg::CoordW-1:0]        cfg_wdata_i,
  input  logic                              in_valid_i,
  input  logic                              in_stall_i,
  input  logic [sbd_pkg::TagW-1:0]          point_tag_i,
  input  logic signed [sbd_pkg::CoordW-1:0] coord_x_i,
  input  logic signed [sbd_pkg::CoordW-1:0] coord_y_i,
  input  logic signed [sbd_pkg::CoordW-1:0] coord_z_i,
  input  logic                              list_end_i,
  input  logic                              out_valid_i,
  input  logic                              out_stall_i,
  input  logic [sbd_pkg::TagW-1:0]          out_tag_i,
  input  logic signed [sbd_pkg::CoordW-1:0] out_x_i,
  input  logic signed [sbd_pkg::CoordW-1:0] out_y_i,
  input  logic signed [sbd_pkg::CoordW-1:0] out_z_i,
  input  logic [sbd_pkg::KeyW-1:0]          dist_sq_i,
  input  logic                              run_end_i,
  input  logic                              overflowed_i,
  output int                                fail_cnt_o,
  output int                                pending_o
);
  import sbd_pkg::*;

  typedef struct packed {
    logic [TagW-1:0]          tag;
    logic signed [CoordW-1:0] x;
    logic signed [CoordW-1:0] y;
    logic signed [CoordW-1:0] z;
    logic [KeyW-1:0]          dist_key;
    logic                     run_end;
    logic                     overflowed;
  } sorted_pt_t;

  sorted_pt_t held_points[$];
  sorted_pt_t sorted_run_q[$];
  logic signed [CoordW-1:0] ref_x, ref_y, ref_z;
  logic nearest_only;
  logic dropped;

  function automatic logic [KeyW-1:0] dist_to_ref(logic signed [CoordW-1:0] x,
                                                  logic signed [CoordW-1:0] y,
                                                  logic signed [CoordW-1:0] z);
    longint dx, dy, dz;
    dx = longint'(x) - longint'(ref_x);
    dy = longint'(y) - longint'(ref_y);
    dz = longint'(z) - longint'(ref_z);
    return KeyW'(dx * dx + dy * dy + dz * dz);
  endfunction

  // stable insertion sort, ties stay in arrival order
  function automatic void queue_sorted_run();
    sorted_pt_t ord[$];
    sorted_pt_t cur;
    int j;
    int n;
    foreach (held_points[i]) begin
      cur = held_points[i];
      j = ord.size();
      ord.push_back(cur);
      while (j > 0 && ord[j-1].dist_key > cur.dist_key) begin
        ord[j] = ord[j-1];
        j--;
      end
      ord[j] = cur;
    end
    n = nearest_only ? 1 : ord.size();
    for (int i = 0; i < n; i++) begin
      cur = ord[i];
      cur.run_end = (i == n - 1);
      cur.overflowed = dropped;
      sorted_run_q.push_back(cur);
    end
    held_points.delete();
    dropped = 1'b0;
  endfunction

  function automatic void compare_field(string name, longint exp_v, longint act_v);
    if (exp_v != act_v) begin
      $error("%s: expected %0d, got %0d", name, exp_v, act_v);
      fail_cnt_o++;
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    sorted_pt_t want;
    sorted_pt_t pt;
    if (!rst_ni) begin
      held_points.delete();
      sorted_run_q.delete();
      ref_x = '0;
      ref_y = '0;
      ref_z = '0;
      nearest_only = 1'b0;
      dropped = 1'b0;
      fail_cnt_o = 0;
      pending_o = 0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (sorted_run_q.size() == 0) begin
          $error("unexpected result, tag %0d", out_tag_i);
          fail_cnt_o++;
        end else begin
          want = sorted_run_q.pop_front();
          compare_field("out_tag", want.tag, out_tag_i);
          compare_field("out_x", want.x, out_x_i);
          compare_field("out_y", want.y, out_y_i);
          compare_field("out_z", want.z, out_z_i);
          compare_field("dist_sq", want.dist_key, dist_sq_i);
          compare_field("run_end", want.run_end, run_end_i);
          compare_field("overflowed", want.overflowed, overflowed_i);
        end
      end
      if (in_valid_i && !in_stall_i) begin
        if (held_points.size() < MAX_POINTS) begin
          pt.tag = point_tag_i;
          pt.x = coord_x_i;
          pt.y = coord_y_i;
          pt.z = coord_z_i;
          pt.dist_key = dist_to_ref(coord_x_i, coord_y_i, coord_z_i);
          pt.run_end = 1'b0;
          pt.overflowed = 1'b0;
          held_points.push_back(pt);
        end else begin
          dropped = 1'b1;
        end
        if (list_end_i) queue_sorted_run();
      end
      if (cfg_we_i) begin
        case (cfg_idx_e'(cfg_idx_i))
          CFG_REF_X:        ref_x = cfg_wdata_i;
          CFG_REF_Y:        ref_y = cfg_wdata_i;
          CFG_REF_Z:        ref_z = cfg_wdata_i;
          CFG_NEAREST_ONLY: nearest_only = cfg_wdata_i[0];
          default: ;
        endcase
      end
      pending_o = sorted_run_q.size();
    end
  end

endmodule

>>> sim/tb_top.sv
`timescale 1ns / 1ps
module tb_top;
  import sbd_pkg::*;

  localparam int unsigned MaxPts   = 64;
  // longest correct gap without any request: a full 64-point sort step plus hold-off
  localparam int unsigned Watchdog = 6000;
  localparam int unsigned HoldOff  = 300;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we = 1'b0;
  logic [CfgIdxW-1:0] cfg_idx = '0;
  logic [CoordW-1:0] cfg_wdata = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [TagW-1:0] point_tag = '0;
  logic signed [CoordW-1:0] coord_x = '0, coord_y = '0, coord_z = '0;
  logic list_end = 1'b0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [TagW-1:0] out_tag;
  logic signed [CoordW-1:0] out_x, out_y, out_z;
  logic [KeyW-1:0] dist_sq;
  logic run_end, overflowed;
  int fail_cnt, pending;

  // stimulus control shared with the receiver process
  logic quiet = 1'b0;       // no random idling on either side
  logic hold_req = 1'b0;    // receiver holds off for a long stretch
  logic signed [CoordW-1:0] last_x = '0, last_y = '0, last_z = '0;

  always #5 clk_i = ~clk_i;

  sort_points_by_distance_core #(.MAX_POINTS(MaxPts)) u_top (
    .clk_i, .rst_ni,
    .cfg_we_i(cfg_we), .cfg_idx_i(cfg_idx), .cfg_wdata_i(cfg_wdata),
    .in_valid_i(in_valid), .in_stall_o(in_stall),
    .point_tag_i(point_tag), .coord_x_i(coord_x), .coord_y_i(coord_y),
    .coord_z_i(coord_z), .list_end_i(list_end),
    .out_valid_o(out_valid), .out_stall_i(out_stall),
    .out_tag_o(out_tag), .out_x_o(out_x), .out_y_o(out_y), .out_z_o(out_z),
    .dist_sq_o(dist_sq), .run_end_o(run_end), .overflowed_o(overflowed)
  );

  // watches all channels, predicts the sorted runs and compares
  sort_points_checker #(.MAX_POINTS(MaxPts)) u_checker (
    .clk_i, .rst_ni,
    .cfg_we_i(cfg_we), .cfg_idx_i(cfg_idx), .cfg_wdata_i(cfg_wdata),
    .in_valid_i(in_valid), .in_stall_i(in_stall),
    .point_tag_i(point_tag), .coord_x_i(coord_x), .coord_y_i(coord_y),
    .coord_z_i(coord_z), .list_end_i(list_end),
    .out_valid_i(out_valid), .out_stall_i(out_stall),
    .out_tag_i(out_tag), .out_x_i(out_x), .out_y_i(out_y), .out_z_i(out_z),
    .dist_sq_i(dist_sq), .run_end_i(run_end), .overflowed_i(overflowed),
    .fail_cnt_o(fail_cnt), .pending_o(pending)
  );

  // receiver: random stall, long hold-off on request
  always @(negedge clk_i) begin
    if (hold_req) begin
      out_stall = 1'b1;
      repeat (HoldOff) @(negedge clk_i);
      hold_req = 1'b0;
      out_stall = 1'b0;
    end else begin
      out_stall = !quiet && ($urandom_range(0, 99) < 10);
    end
  end

  // watchdog: cycles with no request accepted on either side
  always @(posedge clk_i) begin
    int idle_cycles;
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= Watchdog) begin
      $display("sort_points_by_distance_core: mismatch");
      $finish;
    end
  end

  // valid stays high across back-to-back requests, drops only for a gap
  task automatic send_point(logic [TagW-1:0] tag, logic signed [CoordW-1:0] x,
                            logic signed [CoordW-1:0] y,
                            logic signed [CoordW-1:0] z, logic last);
    @(negedge clk_i);
    if (!quiet && $urandom_range(0, 99) < 10) begin
      in_valid = 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk_i);
    end
    in_valid = 1'b1;
    point_tag = tag;
    coord_x = x;
    coord_y = y;
    coord_z = z;
    list_end = last;
    last_x = x;
    last_y = y;
    last_z = z;
    do @(posedge clk_i); while (in_stall);
  endtask

  // all results in, then enough cycles for queued non-final points to load
  task automatic wait_idle();
    @(negedge clk_i);
    in_valid = 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (80) @(negedge clk_i);
  endtask

  task automatic write_reg(cfg_idx_e idx, logic [CoordW-1:0] val);
    @(negedge clk_i);
    cfg_we = 1'b1;
    cfg_idx = idx;
    cfg_wdata = val;
    @(negedge clk_i);
    cfg_we = 1'b0;
  endtask

  task automatic set_ref(logic [CoordW-1:0] x, logic [CoordW-1:0] y,
                         logic [CoordW-1:0] z);
    write_reg(CFG_REF_X, x);
    write_reg(CFG_REF_Y, y);
    write_reg(CFG_REF_Z, z);
  endtask

  // one random list; ties come from repeating the previous point
  task automatic send_random_list(int len);
    logic signed [CoordW-1:0] x, y, z;
    for (int i = 0; i < len; i++) begin
      if ($urandom_range(0, 7) == 0) begin
        x = last_x;
        y = last_y;
        z = last_z;
      end else begin
        x = CoordW'($urandom());
        y = CoordW'($urandom());
        z = CoordW'($urandom());
      end
      send_point(TagW'($urandom()), x, y, z, i == len - 1);
    end
  endtask

  initial begin
    int sent;
    int len;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // directed: reference at origin, extreme coordinates and a tie
    send_point(8'h00, 16'sh0000, 16'sh0000, 16'sh0000, 1'b0);
    send_point(8'hff, 16'sh7fff, 16'sh7fff, 16'sh7fff, 1'b0);
    send_point(8'h01, -16'sh8000, -16'sh8000, -16'sh8000, 1'b0);
    send_point(8'h55, 16'sh0010, -16'sh0010, 16'sh0000, 1'b0);
    send_point(8'haa, 16'sh0010, -16'sh0010, 16'sh0000, 1'b1);
    // single-point list
    send_point(8'h80, 16'sh1234, 16'sh0000, -16'sh0001, 1'b1);
    wait_idle();

    // extreme reference: largest possible distance
    set_ref(16'h7fff, 16'h8000, 16'h7fff);
    send_point(8'h11, -16'sh8000, 16'sh7fff, -16'sh8000, 1'b0);
    send_point(8'h22, 16'sh7fff, -16'sh8000, 16'sh7fff, 1'b0);
    send_point(8'h33, 16'sh0000, 16'sh0000, 16'sh0000, 1'b1);
    wait_idle();

    // nearest only, tie on the nearest keeps the earliest
    write_reg(CFG_NEAREST_ONLY, 16'd1);
    set_ref(16'h8000, 16'h7fff, 16'h8000);
    send_point(8'h44, 16'sh0100, 16'sh0100, 16'sh0100, 1'b0);
    send_point(8'h45, -16'sh8000, 16'sh7fff, -16'sh8000, 1'b0);
    send_point(8'h46, -16'sh8000, 16'sh7fff, -16'sh8000, 1'b0);
    send_point(8'h47, 16'sh7fff, -16'sh8000, 16'sh7fff, 1'b1);
    wait_idle();

    // reference changed in the middle of a list
    write_reg(CFG_NEAREST_ONLY, 16'd0);
    set_ref(16'h0000, 16'h0000, 16'h0000);
    send_point(8'h60, 16'sh0400, 16'sh0000, 16'sh0000, 1'b0);
    send_point(8'h61, 16'sh0000, 16'sh0400, 16'sh0000, 1'b0);
    wait_idle();
    set_ref(16'h0400, 16'h0000, 16'h0000);
    send_point(8'h62, 16'sh0400, 16'sh0000, 16'sh0000, 1'b0);
    send_point(8'h63, 16'sh0000, 16'sh0000, 16'sh0400, 1'b1);
    wait_idle();

    // overflow, including a dropped final point, with the receiver holding off;
    // the next list keeps coming so the queue fills and the input stalls
    hold_req = 1'b1;
    send_random_list(MaxPts + 3);
    send_random_list(8);
    wait_idle();

    // random phases, mostly short lists; one full list with no idling
    sent = 0;
    for (int ph = 0; sent < 120; ph++) begin
      if (ph % 3 == 0) begin
        wait_idle();
        set_ref(CoordW'($urandom()), CoordW'($urandom()), CoordW'($urandom()));
        write_reg(CFG_NEAREST_ONLY, CoordW'($urandom_range(0, 1)));
      end
      quiet = (ph == 4);
      len = (ph == 4) ? MaxPts : $urandom_range(1, 12);
      send_random_list(len);
      sent += len;
      if ($urandom_range(0, 3) == 0) wait_idle();
    end
    quiet = 1'b0;
    wait_idle();
    repeat (200) @(negedge clk_i);

    if (fail_cnt == 0 && pending == 0) begin
      $display("sort_points_by_distance_core: match");
    end else begin
      $display("sort_points_by_distance_core: mismatch");
    end
    $finish;
  end

endmodule
